// File: design/ihfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihfc_pkg
// Shared types and constants for the IPv4 header flow counter.
// ----------------------------------------------------------------------------
package ihfc_pkg;

  localparam int FLOW_ENTRIES = 1024;
  localparam int SLOT_W       = $clog2(FLOW_ENTRIES);
  localparam int CNT_W        = $clog2(FLOW_ENTRIES + 1);
  localparam int CMP_W        = (CNT_W > 10) ? CNT_W : 10;
  localparam int HDR_KEEP     = 38;

  localparam logic [7:0] ETYPE_HI  = 8'h08;
  localparam logic [7:0] ETYPE_LO  = 8'h00;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  typedef enum logic [2:0] {
    ST_HIT        = 3'd0,
    ST_NEW        = 3'd1,
    ST_FULL       = 3'd2,
    ST_NOT_IPV4   = 3'd3,
    ST_SHORT      = 3'd4,
    ST_READ_VALID = 3'd5,
    ST_READ_EMPTY = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    PC_TCP   = 2'd0,
    PC_UDP   = 2'd1,
    PC_OTHER = 2'd2
  } proto_class_t;

  typedef enum logic [1:0] {
    T_IDLE,
    T_EVAL,
    T_FLOW
  } top_state_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CMP,
    F_RD
  } flow_state_t;

  typedef struct packed {
    logic        rd;
    logic [63:0] key;
    logic [9:0]  ridx;
  } flow_req_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] key;
    logic [9:0]  slot;
    logic [31:0] hits;
  } flow_rsp_t;

  typedef struct packed {
    logic [31:0]  packet_number;
    logic [47:0]  mac_first;
    logic [47:0]  mac_second;
    status_t      status;
    logic [31:0]  src_addr;
    logic [31:0]  dst_addr;
    proto_class_t proto_class;
    logic [15:0]  src_port;
    logic [15:0]  dst_port;
    logic [9:0]   flow_slot;
    logic [31:0]  flow_hits;
  } result_t;

endpackage

// File: design/ihfc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihfc_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface ihfc_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;
  logic       last_byte;
  logic [9:0] read_index;

  modport source (output valid, mode, data_byte, last_byte, read_index, input ready);
  modport sink   (input valid, mode, data_byte, last_byte, read_index, output ready);
endinterface

interface ihfc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] packet_number;
  logic [47:0] mac_first;
  logic [47:0] mac_second;
  logic [2:0]  status;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [1:0]  proto_class;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic [9:0]  flow_slot;
  logic [31:0] flow_hits;

  modport source (output valid, packet_number, mac_first, mac_second, status, src_addr,
                  dst_addr, proto_class, src_port, dst_port, flow_slot, flow_hits,
                  input ready);
  modport sink   (input valid, packet_number, mac_first, mac_second, status, src_addr,
                  dst_addr, proto_class, src_port, dst_port, flow_slot, flow_hits,
                  output ready);
endinterface

// File: design/ipv4_header_flow_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_header_flow_counter
// Ethernet/IPv4 header parser with an address-pair flow counting table.
// ----------------------------------------------------------------------------
// Frame bytes are taken one per cycle, while the input is ready, into a row
// of 38 byte cells. The last byte of a frame is followed by an evaluation
// state; an IPv4 frame that holds both addresses then searches the flow table
// one entry per cycle, and no new item is taken until the search ends. A
// readout of an index in use goes through the table's read state; an index
// not in use is answered without it. The next item is taken only while no
// result is waiting, or when that result transfers in the same cycle.
module ipv4_header_flow_counter (
  input  logic clk,
  input  logic rst_n,
  ihfc_in_if.sink    in_ch,
  ihfc_out_if.source out_ch
);
  import ihfc_pkg::*;

  top_state_t  state_r, state_nxt;
  logic [31:0] frame_cnt_r;
  logic        rd_r;
  result_t     out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic        acc, byte_load, cell_clear;
  logic [HDR_KEEP-1:0] filled;
  logic [7:0]  hdr [HDR_KEEP];

  logic        req_valid, done;
  flow_req_t   req;
  flow_rsp_t   rsp;

  logic        is_ipv4, need_lookup;
  logic [7:0]  proto;

  assign in_ch.ready = (state_r == T_IDLE) && (!out_valid_r || out_ch.ready);
  assign acc         = in_ch.valid && in_ch.ready;
  assign byte_load   = acc && !in_ch.mode;
  assign cell_clear  = state_r == T_EVAL;

  for (genvar i = 0; i < HDR_KEEP; i++) begin : g_cell
    ihfc_byte_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .load        (byte_load),
      .clear       (cell_clear),
      .prev_filled ((i == 0) ? 1'b1 : filled[(i == 0) ? 0 : i - 1]),
      .din         (in_ch.data_byte),
      .filled      (filled[i]),
      .dout        (hdr[i])
    );
  end

  ihfc_flow_table u_flow (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req       (req),
    .done      (done),
    .rsp       (rsp)
  );

  assign is_ipv4     = (hdr[12] == ETYPE_HI) && (hdr[13] == ETYPE_LO);
  assign need_lookup = filled[13] && is_ipv4 && filled[33];
  assign proto       = hdr[23];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      frame_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (byte_load && in_ch.last_byte) frame_cnt_r <= frame_cnt_r + 32'd1;
    end
    if (acc) rd_r <= in_ch.mode;
    out_r <= out_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      T_IDLE: begin
        if (acc && in_ch.mode) state_nxt = done ? T_IDLE : T_FLOW;
        else if (byte_load && in_ch.last_byte) state_nxt = T_EVAL;
      end
      T_EVAL:  state_nxt = (need_lookup && !done) ? T_FLOW : T_IDLE;
      T_FLOW:  if (done) state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  always_comb begin
    req_valid     = 1'b0;
    req.rd        = 1'b1;
    req.key       = {hdr[26], hdr[27], hdr[28], hdr[29], hdr[30], hdr[31], hdr[32], hdr[33]};
    req.ridx      = in_ch.read_index;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    case (state_r)
      T_IDLE: begin
        if (acc && in_ch.mode) begin
          req_valid = 1'b1;
          // an index not in use answers in the same cycle
          if (done) begin
            out_valid_nxt         = 1'b1;
            out_nxt               = '0;
            out_nxt.packet_number = frame_cnt_r;
            out_nxt.status        = rsp.status;
            out_nxt.flow_slot     = rsp.slot;
          end
        end
      end
      T_EVAL: begin
        out_nxt               = '0;
        out_nxt.packet_number = frame_cnt_r;
        out_nxt.mac_first     = {hdr[0], hdr[1], hdr[2], hdr[3], hdr[4], hdr[5]};
        out_nxt.mac_second    = {hdr[6], hdr[7], hdr[8], hdr[9], hdr[10], hdr[11]};
        out_nxt.proto_class   = PC_OTHER;
        if (!filled[13])   out_nxt.status = ST_SHORT;
        else if (!is_ipv4) out_nxt.status = ST_NOT_IPV4;
        else               out_nxt.status = ST_SHORT;
        if (need_lookup) begin
          req_valid        = 1'b1;
          req.rd           = 1'b0;
          out_nxt.src_addr = req.key[63:32];
          out_nxt.dst_addr = req.key[31:0];
          if (proto == PROTO_TCP || proto == PROTO_UDP) begin
            out_nxt.proto_class = (proto == PROTO_TCP) ? PC_TCP : PC_UDP;
            out_nxt.src_port    = {hdr[34], hdr[35]};
            out_nxt.dst_port    = {hdr[36], hdr[37]};
          end
          // empty table: new entry without a search
          if (done) begin
            out_valid_nxt     = 1'b1;
            out_nxt.status    = rsp.status;
            out_nxt.flow_slot = rsp.slot;
            out_nxt.flow_hits = rsp.hits;
          end
        end else begin
          out_valid_nxt = 1'b1;
        end
      end
      T_FLOW: begin
        if (done) begin
          out_valid_nxt     = 1'b1;
          out_nxt.status    = rsp.status;
          out_nxt.flow_slot = rsp.slot;
          out_nxt.flow_hits = rsp.hits;
          if (rd_r) begin
            out_nxt.packet_number = frame_cnt_r;
            out_nxt.mac_first     = '0;
            out_nxt.mac_second    = '0;
            out_nxt.src_addr      = rsp.key[63:32];
            out_nxt.dst_addr      = rsp.key[31:0];
            out_nxt.proto_class   = PC_TCP;
            out_nxt.src_port      = '0;
            out_nxt.dst_port      = '0;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.packet_number = out_r.packet_number;
  assign out_ch.mac_first     = out_r.mac_first;
  assign out_ch.mac_second    = out_r.mac_second;
  assign out_ch.status        = out_r.status;
  assign out_ch.src_addr      = out_r.src_addr;
  assign out_ch.dst_addr      = out_r.dst_addr;
  assign out_ch.proto_class   = out_r.proto_class;
  assign out_ch.src_port      = out_r.src_port;
  assign out_ch.dst_port      = out_r.dst_port;
  assign out_ch.flow_slot     = out_r.flow_slot;
  assign out_ch.flow_hits     = out_r.flow_hits;
endmodule

// File: design/ihfc_byte_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihfc_byte_cell
// One header byte slot; fills when its left neighbor is full.
// ----------------------------------------------------------------------------
module ihfc_byte_cell (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  logic       clear,
  input  logic       prev_filled,
  input  logic [7:0] din,
  output logic       filled,
  output logic [7:0] dout
);
  logic       filled_r;
  logic [7:0] byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      filled_r <= 1'b0;
      byte_r   <= 8'd0;
    end else if (load && prev_filled && !filled_r) begin
      filled_r <= 1'b1;
      byte_r   <= din;
    end
  end

  assign filled = filled_r;
  assign dout   = byte_r;
endmodule

// File: design/ihfc_flow_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihfc_flow_table
// Flow table: linear key search, saturating counts, append, readout.
// ----------------------------------------------------------------------------
module ihfc_flow_table (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 req_valid,
  input  ihfc_pkg::flow_req_t  req,
  output logic                 done,
  output ihfc_pkg::flow_rsp_t  rsp
);
  import ihfc_pkg::*;

  logic [63:0] keys_mem [FLOW_ENTRIES];
  logic [31:0] cnt_mem  [FLOW_ENTRIES];

  flow_state_t       state_r, state_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic [63:0]       key_r, key_nxt;
  logic [63:0]       rd_key_r;
  logic [31:0]       rd_cnt_r;

  logic              we;
  logic [SLOT_W-1:0] waddr, raddr;
  logic [63:0]       wkey;
  logic [31:0]       wcnt;

  logic [CMP_W-1:0]  ridx_ext, used_ext, idx_next_ext, idx_ext, used_slot_ext;
  logic              in_use, hit, full, more;
  logic [31:0]       cnt_inc;

  assign ridx_ext      = CMP_W'(req.ridx);
  assign used_ext      = CMP_W'(used_r);
  assign idx_ext       = CMP_W'(idx_r);
  assign idx_next_ext  = idx_ext + CMP_W'(1);
  assign used_slot_ext = CMP_W'(used_r);
  assign in_use        = ridx_ext < used_ext;
  assign hit           = rd_key_r == key_r;
  assign full          = used_r == CNT_W'(FLOW_ENTRIES);
  assign more          = idx_next_ext < used_ext;
  assign cnt_inc       = (&rd_cnt_r) ? rd_cnt_r : rd_cnt_r + 32'd1;

  always_ff @(posedge clk) begin
    if (we) begin
      keys_mem[waddr] <= wkey;
      cnt_mem[waddr]  <= wcnt;
    end
    rd_key_r <= keys_mem[raddr];
    rd_cnt_r <= cnt_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      used_r  <= '0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
    end
    idx_r <= idx_nxt;
    key_r <= key_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (req_valid) begin
          if (req.rd) begin
            if (in_use) state_nxt = F_RD;
          end else if (used_r != '0) begin
            state_nxt = F_CMP;
          end
        end
      end
      F_CMP: begin
        if (hit || !more) state_nxt = F_IDLE;
      end
      F_RD:    state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    done       = 1'b0;
    rsp        = '0;
    rsp.status = ST_HIT;
    we         = 1'b0;
    waddr      = idx_r;
    wkey       = key_r;
    wcnt       = cnt_inc;
    raddr      = idx_r + SLOT_W'(1);   // prefetch next entry while comparing
    idx_nxt    = idx_r;
    used_nxt   = used_r;
    key_nxt    = key_r;
    case (state_r)
      F_IDLE: begin
        key_nxt = req.key;
        raddr   = req.rd ? ridx_ext[SLOT_W-1:0] : '0;
        idx_nxt = req.rd ? ridx_ext[SLOT_W-1:0] : '0;
        if (req_valid) begin
          if (req.rd) begin
            if (!in_use) begin
              done       = 1'b1;
              rsp.status = ST_READ_EMPTY;
              rsp.slot   = req.ridx;
            end
          end else if (used_r == '0) begin
            we         = 1'b1;
            waddr      = used_slot_ext[SLOT_W-1:0];
            wkey       = req.key;
            wcnt       = 32'd1;
            used_nxt   = used_r + CNT_W'(1);
            done       = 1'b1;
            rsp.status = ST_NEW;
            rsp.key    = req.key;
            rsp.slot   = used_slot_ext[9:0];
            rsp.hits   = 32'd1;
          end
        end
      end
      F_CMP: begin
        if (hit) begin
          we         = 1'b1;
          done       = 1'b1;
          rsp.status = ST_HIT;
          rsp.key    = key_r;
          rsp.slot   = idx_ext[9:0];
          rsp.hits   = cnt_inc;
        end else if (more) begin
          idx_nxt = idx_r + SLOT_W'(1);
        end else if (!full) begin
          we         = 1'b1;
          waddr      = used_slot_ext[SLOT_W-1:0];
          wcnt       = 32'd1;
          used_nxt   = used_r + CNT_W'(1);
          done       = 1'b1;
          rsp.status = ST_NEW;
          rsp.key    = key_r;
          rsp.slot   = used_slot_ext[9:0];
          rsp.hits   = 32'd1;
        end else begin
          done       = 1'b1;
          rsp.status = ST_FULL;
          rsp.key    = key_r;
        end
      end
      F_RD: begin
        done       = 1'b1;
        rsp.status = ST_READ_VALID;
        rsp.key    = rd_key_r;
        rsp.slot   = idx_ext[9:0];
        rsp.hits   = rd_cnt_r;
      end
      default: ;
    endcase
  end

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(used_r) <= CMP_W'(FLOW_ENTRIES))
    else $error("flow table fill count beyond capacity");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == F_CMP |-> idx_ext < used_ext)
    else $error("scan index past filled entries");

  a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
    used_r != $past(used_r) |-> used_r == $past(used_r) + CNT_W'(1))
    else $error("fill count moved by more than one");

  a_busy_no_req: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != F_IDLE |-> !req_valid)
    else $error("request while lookup in progress");
endmodule
